FILE: rtl/pfr_pkg.sv
package pfr_pkg;

   localparam int MAX_FRAMES   = 16;
   localparam int FRAME_W      = $clog2(MAX_FRAMES);
   localparam int FCNT_W       = $clog2(MAX_FRAMES + 1);
   localparam int ADDR_W       = 32;
   localparam int PAGE_W       = 28;
   localparam int STAMP_W      = 32;
   localparam int OFF_W        = 5;
   localparam int OFF_MAX_W    = 16;
   localparam int PNB_W        = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [OFF_W-1:0]  OFF_MIN       = OFF_W'(4);
   localparam logic [OFF_W-1:0]  OFF_MAX       = OFF_W'(OFF_MAX_W);
   localparam logic [OFF_W-1:0]  OFF_RESET     = OFF_W'(12);
   localparam logic [FCNT_W-1:0] FRAMES_MAX    = FCNT_W'(MAX_FRAMES);
   localparam logic [FCNT_W-1:0] FRAMES_RESET  = FCNT_W'(MAX_FRAMES);
   localparam logic [PNB_W-1:0]  PNB_RESET     = PNB_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS      = 2'd0,
      CSR_REPLACE_POLICY   = 2'd1,
      CSR_FRAMES_IN_USE    = 2'd2,
      CSR_PAGE_NUMBER_BITS = 2'd3
   } csr_index_type;

   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   // Configuration as the datapath sees it, already clamped to legal ranges.
   typedef struct packed {
      logic [OFF_W-1:0]  offset_bits;
      policy_type        policy;
      logic [FCNT_W-1:0] frame_count;
      logic [PNB_W-1:0]  page_number_bits;
   } cfg_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] load_time;
      logic [STAMP_W-1:0] access_time;
   } frame_entry_type;

   localparam int ENTRY_W = $bits(frame_entry_type);

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] hit_idx;
      logic [STAMP_W-1:0] hit_load;
      logic               free;
      logic [FRAME_W-1:0] free_idx;
      logic [FRAME_W-1:0] oldest_idx;
      logic [PAGE_W-1:0]  oldest_page;
   } scan_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

FILE: rtl/pfr_req_if.sv
interface pfr_req_if;
   import pfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] virtual_address;

   modport source (output valid, output virtual_address, input ready);
   modport sink   (input valid, input virtual_address, output ready);

endinterface

FILE: rtl/pfr_rsp_if.sv
interface pfr_rsp_if;
   import pfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  physical_address;
   logic [FRAME_W-1:0] frame_index;
   logic               was_hit;
   logic               did_evict;
   logic [PAGE_W-1:0]  evicted_page;
   logic               address_invalid;

   modport source (output valid, output physical_address, output frame_index,
                   output was_hit, output did_evict, output evicted_page,
                   output address_invalid, input ready);
   modport sink   (input valid, input physical_address, input frame_index,
                   input was_hit, input did_evict, input evicted_page,
                   input address_invalid, output ready);

endinterface

FILE: rtl/pfr_frame_ram.sv
module pfr_frame_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/pfr_csr.sv
module pfr_csr
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   logic [OFF_W-1:0]  offset_bits_ff;
   logic              policy_ff;
   logic [FCNT_W-1:0] frames_ff;
   logic [PNB_W-1:0]  pnb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFF_RESET;
         policy_ff      <= POLICY_FIFO;
         frames_ff      <= FRAMES_RESET;
         pnb_ff         <= PNB_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_BITS:      offset_bits_ff <= csr_write_data[OFF_W-1:0];
            CSR_REPLACE_POLICY:   policy_ff      <= csr_write_data[0];
            CSR_FRAMES_IN_USE:    frames_ff      <= csr_write_data[FCNT_W-1:0];
            CSR_PAGE_NUMBER_BITS: pnb_ff         <= csr_write_data[PNB_W-1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range settings act as the nearest legal value.
   always_comb begin
      cfg.offset_bits = (offset_bits_ff < OFF_MIN) ? OFF_MIN :
                        (offset_bits_ff > OFF_MAX) ? OFF_MAX : offset_bits_ff;
      cfg.policy      = policy_ff ? POLICY_LRU : POLICY_FIFO;
      cfg.frame_count = (frames_ff == '0) ? FCNT_W'(1) :
                        (frames_ff > FRAMES_MAX) ? FRAMES_MAX : frames_ff;
      cfg.page_number_bits = pnb_ff;
   end

endmodule

FILE: rtl/pfr_scan.sv
module pfr_scan
   import pfr_pkg::*;
(
   input  logic               clock,
   input  logic               start,
   input  logic               enable,
   input  logic [FRAME_W-1:0] idx,
   input  frame_entry_type    entry,
   input  logic               entry_valid,
   input  logic [PAGE_W-1:0]  page,
   input  policy_type         policy,
   output scan_type           result
);

   scan_type           res_ff, res_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [STAMP_W-1:0] stamp;

   always_comb begin
      res_in    = res_ff;
      oldest_in = oldest_ff;
      stamp     = (policy == POLICY_LRU) ? entry.access_time : entry.load_time;
      if (start) begin
         res_in.hit  = 1'b0;
         res_in.free = 1'b0;
      end else if (enable) begin
         // First valid match wins; a free frame never matches.
         if (entry_valid && entry.page == page && !res_ff.hit) begin
            res_in.hit      = 1'b1;
            res_in.hit_idx  = idx;
            res_in.hit_load = entry.load_time;
         end
         if (!entry_valid && !res_ff.free) begin
            res_in.free     = 1'b1;
            res_in.free_idx = idx;
         end
         // Strict compare keeps the lowest index among equal stamps.
         if (idx == '0 || stamp < oldest_ff) begin
            oldest_in          = stamp;
            res_in.oldest_idx  = idx;
            res_in.oldest_page = entry.page;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      oldest_ff <= oldest_in;
   end

   assign result = res_ff;

endmodule

FILE: rtl/page_frame_replacement_core.sv
// Demand-paging frame allocator with FIFO or LRU replacement. Each request
// item carries one virtual address; the core splits it into page number and
// offset using offset_bits, looks the page up among the first frames_in_use
// frames, and returns one response item with the physical address, the frame
// now holding the page, hit and eviction flags, the evicted page (zero when
// nothing was evicted) and a flag for a page number beyond page_number_bits.
// On a miss the lowest free frame is taken; with no free frame the frame with
// the oldest load stamp (FIFO) or oldest access stamp (LRU) is replaced, the
// lowest index winning ties. Stamps come from a 32-bit access counter that
// saturates at all ones. Frame contents live in a single one-read, one-write
// RAM that is walked one frame per cycle, so an item occupies the core from
// its request accept through the walk and the write-back; no new request is
// accepted before then. A finished response sits in an output register,
// so the next request is accepted while it waits; the core stalls only if a
// second response is ready before the first has been taken. Configuration
// writes are expected only while the core is idle. No clearing pass is
// needed after reset: per-frame valid flags are held in flops and cleared at
// once.
module page_frame_replacement_core
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pfr_req_if.sink               req_chan,
   pfr_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg;

   pfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Control state.
   state_type          state_ff, state_in;
   logic [FCNT_W-1:0]  iss_cnt_ff, iss_cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [FRAME_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-item context, captured when a request item is accepted.
   logic [PAGE_W-1:0]    page_ff;
   logic [OFF_MAX_W-1:0] offset_ff;
   logic [OFF_W-1:0]     off_ff;
   policy_type           policy_ff;
   logic [FCNT_W-1:0]    nf_ff;
   logic [PNB_W-1:0]     pnb_ff;

   // Response payload registers.
   logic [ADDR_W-1:0]  phys_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic               hit_ff;
   logic               evict_ff;
   logic [PAGE_W-1:0]  evicted_ff;
   logic               invalid_ff;

   logic               req_fire;
   logic               rd_en;
   logic               last_cmp;
   logic               commit;
   logic [FRAME_W-1:0] nf_last;
   logic [FRAME_W-1:0] frame_sel;
   logic [ENTRY_W-1:0] rd_data;
   frame_entry_type    rd_entry;
   frame_entry_type    wr_entry;
   scan_type           scan;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Reads are issued while the walk has frames left; data returns in the cycle
   // after and is judged by the scan unit.
   assign rd_en    = (state_ff == S_SCAN) && (iss_cnt_ff < nf_ff);
   assign nf_last  = FRAME_W'(nf_ff - FCNT_W'(1));
   assign last_cmp = cmp_vld_ff && (cmp_idx_ff == nf_last);

   // The result may be written back only when the output register is free
   // or is being emptied in this very cycle.
   assign commit = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   pfr_frame_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (frame_sel),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (iss_cnt_ff[FRAME_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry = frame_entry_type'(rd_data);

   pfr_scan u_scan (
      .clock       (clock),
      .start       (req_fire),
      .enable      (cmp_vld_ff),
      .idx         (cmp_idx_ff),
      .entry       (rd_entry),
      .entry_valid (valid_ff[cmp_idx_ff]),
      .page        (page_ff),
      .policy      (policy_ff),
      .result      (scan)
   );

   // Frame choice: a hit keeps its frame, else the lowest free frame, else
   // the oldest frame by the selected stamp.
   always_comb begin
      if (scan.hit) begin
         frame_sel = scan.hit_idx;
      end else if (scan.free) begin
         frame_sel = scan.free_idx;
      end else begin
         frame_sel = scan.oldest_idx;
      end
      wr_entry.page        = page_ff;
      wr_entry.load_time   = scan.hit ? scan.hit_load : counter_ff;
      wr_entry.access_time = counter_ff;
   end

   always_comb begin
      state_in     = state_ff;
      iss_cnt_in   = iss_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      valid_in     = valid_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               iss_cnt_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               iss_cnt_in = iss_cnt_ff + FCNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_cnt_ff[FRAME_W-1:0];
            end
            if (last_cmp) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               valid_in[frame_sel] = 1'b1;
               if (counter_ff != '1) begin
                  counter_in = counter_ff + STAMP_W'(1);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_cnt_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         cmp_idx_ff   <= '0;
         valid_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_cnt_ff   <= iss_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_idx_ff   <= cmp_idx_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Address split. The offset width is at least four bits, so the page
   // number always fits in its 28-bit field.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         page_ff   <= PAGE_W'(req_chan.virtual_address >> cfg.offset_bits);
         offset_ff <= OFF_MAX_W'(req_chan.virtual_address &
                                 ~({ADDR_W{1'b1}} << cfg.offset_bits));
         off_ff    <= cfg.offset_bits;
         policy_ff <= cfg.policy;
         nf_ff     <= cfg.frame_count;
         pnb_ff    <= cfg.page_number_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         phys_ff    <= (ADDR_W'(frame_sel) << off_ff) | ADDR_W'(offset_ff);
         frame_ff   <= frame_sel;
         hit_ff     <= scan.hit;
         evict_ff   <= !scan.hit && !scan.free;
         evicted_ff <= (!scan.hit && !scan.free) ? scan.oldest_page : '0;
         invalid_ff <= (page_ff >> pnb_ff) != '0;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.physical_address = phys_ff;
   assign rsp_chan.frame_index      = frame_ff;
   assign rsp_chan.was_hit          = hit_ff;
   assign rsp_chan.did_evict        = evict_ff;
   assign rsp_chan.evicted_page     = evicted_ff;
   assign rsp_chan.address_invalid  = invalid_ff;

endmodule
